>>> src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, microcode and sound tables of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

	// step counter width and step addresses
	localparam int StepW = 4;

	localparam logic [StepW-1:0] S_IDLE     = 4'd0;
	localparam logic [StepW-1:0] S_DISPATCH = 4'd1;
	localparam logic [StepW-1:0] S_T_INC    = 4'd2;
	localparam logic [StepW-1:0] S_T_END    = 4'd3;
	localparam logic [StepW-1:0] S_T_POP    = 4'd4;
	localparam logic [StepW-1:0] S_T_DIV    = 4'd5;
	localparam logic [StepW-1:0] S_T_WAIT   = 4'd6;
	localparam logic [StepW-1:0] S_T_DUR    = 4'd7;
	localparam logic [StepW-1:0] S_Q_CHECK  = 4'd8;
	localparam logic [StepW-1:0] S_Q_COPY   = 4'd9;
	localparam logic [StepW-1:0] S_DONE     = 4'd10;

	// jump conditions, jump taken when true
	localparam logic [2:0] C_NEVER  = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_IDLE   = 3'd2;
	localparam logic [2:0] C_QUEUE  = 3'd3;
	localparam logic [2:0] C_SKIP   = 3'd4;
	localparam logic [2:0] C_MORE   = 3'd5;
	localparam logic [2:0] C_NO_POP = 3'd6;

	// tone ends unless deadline is 1..WRAP_GUARD-1 ticks ahead
	localparam logic [31:0] WRAP_GUARD = 32'd1000;

	localparam int RomAw = 6;
	localparam int LenW  = 5;

	// control word
	typedef struct packed {
		logic             time_inc;
		logic             end_check;
		logic             q_check;
		logic             copy;
		logic             pop_div;
		logic             pop_dur;
		logic [2:0]       cond;
		logic [StepW-1:0] target;
	} ucw_t;

	// condition inputs from the datapath
	typedef struct packed {
		logic start;
		logic queue;
		logic skip;
		logic more;
		logic no_pop;
	} tsp_flags_t;

	// control store
	function automatic ucw_t tsp_ucode(input logic [StepW-1:0] step);
		ucw_t w;
		w = '0;
		case (step)
			S_IDLE: begin
				w.cond = C_IDLE;
				w.target = S_IDLE;
			end
			S_DISPATCH: begin
				w.cond = C_QUEUE;
				w.target = S_Q_CHECK;
			end
			S_T_INC: begin
				w.time_inc = 1'b1;
			end
			S_T_END: begin
				w.end_check = 1'b1;
			end
			S_T_POP: begin
				w.cond = C_NO_POP;
				w.target = S_DONE;
			end
			S_T_DIV: begin
				w.pop_div = 1'b1;
			end
			S_T_WAIT: begin
				w.cond = C_NEVER;
			end
			S_T_DUR: begin
				w.pop_dur = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_DONE;
			end
			S_Q_CHECK: begin
				w.q_check = 1'b1;
				w.cond = C_SKIP;
				w.target = S_DONE;
			end
			S_Q_COPY: begin
				w.copy = 1'b1;
				w.cond = C_MORE;
				w.target = S_Q_COPY;
			end
			S_DONE: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

	// first rom word of each sound
	function automatic logic [RomAw-1:0] snd_base(input logic [3:0] id);
		case (id)
			4'd4:    return 6'd2;
			4'd5:    return 6'd6;
			4'd6:    return 6'd8;
			4'd7:    return 6'd10;
			4'd8:    return 6'd12;
			default: return 6'd0;
		endcase
	endfunction

	// word count of each sound, zero for none
	function automatic logic [LenW-1:0] snd_len(input logic [3:0] id);
		case (id)
			4'd3:    return 5'd2;
			4'd4:    return 5'd4;
			4'd5:    return 5'd2;
			4'd6:    return 5'd2;
			4'd7:    return 5'd2;
			4'd8:    return 5'd24;
			default: return 5'd0;
		endcase
	endfunction

	// divisor and duration pairs of all sounds
	function automatic logic [15:0] snd_word(input logic [RomAw-1:0] idx);
		case (idx)
			6'd0:    return 16'd662;
			6'd1:    return 16'd5;
			6'd2:    return 16'd376;
			6'd3:    return 16'd3;
			6'd4:    return 16'd316;
			6'd5:    return 16'd3;
			6'd6:    return 16'd4800;
			6'd7:    return 16'd3;
			6'd8:    return 16'd2000;
			6'd9:    return 16'd10;
			6'd10:   return 16'd8000;
			6'd11:   return 16'd20;
			6'd12:   return 16'd2000;
			6'd14:   return 16'd1800;
			6'd16:   return 16'd1700;
			6'd18:   return 16'd1500;
			6'd20:   return 16'd1400;
			6'd22:   return 16'd1300;
			6'd24:   return 16'd1200;
			6'd26:   return 16'd1000;
			6'd28:   return 16'd900;
			6'd30:   return 16'd800;
			6'd32:   return 16'd700;
			6'd34:   return 16'd500;
			6'd13, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23,
			6'd25, 6'd27, 6'd29, 6'd31, 6'd33, 6'd35:
				return 16'd2;
			default: return 16'd0;
		endcase
	endfunction

endpackage

>>> src/tsp_useq.sv
// ----------------------------------------------------------------------------
// tsp_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module tsp_useq
	import tsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  tsp_flags_t flags,
	output ucw_t       ucw,
	output logic       busy,
	output logic       done
);

	logic [StepW-1:0] step_q;
	logic             take;

	assign ucw = tsp_ucode(step_q);

	// condition select
	always_comb begin
		case (ucw.cond)
			C_NEVER:  take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_IDLE:   take = !flags.start;
			C_QUEUE:  take = flags.queue;
			C_SKIP:   take = flags.skip;
			C_MORE:   take = flags.more;
			C_NO_POP: take = flags.no_pop;
			default:  take = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= ucw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	assign busy = (step_q != S_IDLE);
	assign done = (step_q == S_DONE);

endmodule

>>> src/tone_sequence_player_top.sv
// ----------------------------------------------------------------------------
// tone_sequence_player_top
// Speaker tone sequencer with a sound rom, a ring fifo and a tick timer.
// ----------------------------------------------------------------------------
// Usage:
//   start/busy command port: a transaction is taken at a clock edge with
//   start high and busy low. mode 0 is one time tick, mode 1 queues the
//   built-in sound sound_id (copied whole into the fifo, dropped, or ignored).
//   done is high for one cycle with tone_on, tone_divisor, sound_dropped and
//   waiting; the receiver cannot stall, results must be taken then.
//   cfg_valid/cfg_ready writes sound_enable from cfg_data while idle.
// Steps, from the accepting edge to the done cycle: a tick runs dispatch,
//   time increment, end check and pop check; a tick that starts a tone adds
//   divisor pop, wait and duration pop. A queue runs dispatch and check, then
//   copies the sound unless it is ignored or dropped. busy falls after done.
//   The queue copy moves one rom word per cycle and the fifo read port gives
//   one word per cycle; a microcode sequencer runs all.
// Reset: fifo empty, time and deadline zero, tone off, sound_enable set.
// ----------------------------------------------------------------------------
module tone_sequence_player_top
	import tsp_pkg::*;
#(
	parameter int FIFO_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [3:0]  sound_id,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        done,
	output logic        tone_on,
	output logic [15:0] tone_divisor,
	output logic        sound_dropped,
	output logic        waiting
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = ((PW > LenW) ? PW : LenW) + 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

	ucw_t       ucw;
	tsp_flags_t flags;

	logic          enable_q;
	logic          mode_q;
	logic [3:0]    id_q;
	logic          dropped_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [31:0]   time_q;
	logic [31:0]   deadline_q;
	logic          pending_q;
	logic          gate_q;
	logic [15:0]   divisor_q;
	logic [LenW-1:0] k_q;
	logic [15:0]   rd_q;
	logic [15:0]   fifo_mem [FIFO_DEPTH];

	logic            accept;
	logic [LenW-1:0] len;
	logic [RomAw-1:0] rom_idx;
	logic [PW-1:0]   head_nxt;
	logic [PW-1:0]   tail_nxt;
	logic [PW-1:0]   used;
	logic [CW-1:0]   free_words;
	logic            no_room;
	logic [31:0]     ahead;
	logic            tone_end;

	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	// sequencer
	tsp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ucw    (ucw),
		.busy   (busy),
		.done   (done)
	);

	// sound lookup and fifo occupancy
	assign len      = snd_len(id_q);
	assign rom_idx  = snd_base(id_q) + RomAw'(k_q);
	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

	always_comb begin
		if (head_q >= tail_q) begin
			used = head_q - tail_q;
		end else begin
			used = PW'((PW+1)'(head_q) + (PW+1)'(FIFO_DEPTH) - (PW+1)'(tail_q));
		end
	end

	assign free_words = CW'(PTR_LAST) - CW'(used);
	assign no_room    = CW'(len) > free_words;

	// deadline test with wrap guard
	assign ahead    = deadline_q - time_q;
	assign tone_end = (ahead == 32'd0) || (ahead >= WRAP_GUARD);

	// jump conditions
	always_comb begin
		flags.start  = start;
		flags.queue  = mode_q;
		flags.skip   = !enable_q || (len == '0) || no_room;
		flags.more   = (k_q != len - 1'b1);
		flags.no_pop = pending_q || (tail_q == head_q);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			id_q      <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode;
			id_q      <= sound_id;
			dropped_q <= 1'b0;
		end else if (ucw.q_check) begin
			dropped_q <= enable_q && (len != '0) && no_room;
		end
	end

	// fifo pointers and copy counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			k_q    <= '0;
		end else begin
			if (ucw.q_check) begin
				k_q <= '0;
			end
			if (ucw.copy) begin
				head_q <= head_nxt;
				k_q    <= k_q + 1'b1;
			end
			if (ucw.pop_div || ucw.pop_dur) begin
				tail_q <= tail_nxt;
			end
		end
	end

	// fifo storage, read data registered
	always_ff @(posedge clk) begin
		if (ucw.copy) begin
			fifo_mem[head_q] <= snd_word(rom_idx);
		end
		rd_q <= fifo_mem[tail_q];
	end

	// time, deadline and tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			deadline_q <= '0;
			pending_q  <= 1'b0;
			gate_q     <= 1'b0;
			divisor_q  <= '0;
		end else begin
			if (ucw.time_inc) begin
				time_q <= time_q + 1'b1;
			end
			if (ucw.end_check && pending_q && tone_end) begin
				pending_q <= 1'b0;
				gate_q    <= 1'b0;
			end
			if (ucw.pop_div) begin
				divisor_q <= rd_q;
			end
			if (ucw.pop_dur) begin
				deadline_q <= time_q + {16'd0, rd_q};
				pending_q  <= 1'b1;
				gate_q     <= 1'b1;
			end
		end
	end

	assign tone_on       = gate_q;
	assign tone_divisor  = divisor_q;
	assign sound_dropped = dropped_q;
	assign waiting       = pending_q;

	// the fifo never fills its last slot
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ucw.copy |-> (head_nxt != tail_q))
		else $error("fifo copy would overrun the tail");

	// a tone is only popped from a non-empty fifo
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ucw.pop_div |-> (tail_q != head_q))
		else $error("pop from empty fifo");

	// gate and pending deadline move together
	a_gate_pending: assert property (@(posedge clk) disable iff (!arst_n)
		tone_on == waiting)
		else $error("speaker gate out of step with deadline");

	// time only advances on a tick step
	a_time_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(time_q != $past(time_q)) |-> $past(ucw.time_inc))
		else $error("time advanced outside a tick");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction not started");

endmodule

>>> sim/tone_tb_pkg.sv
// ----------------------------------------------------------------------------
// tone_tb_pkg
// Result type, sound table and status tracker for the tone sequence player
// bench. The tracker mirrors the ring fifo, tick timer and tone gate, and
// holds the status values each accepted transaction should produce.
// ----------------------------------------------------------------------------
package tone_tb_pkg;

	// command modes
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_QUEUE = 1'b1;

	// built-in sound ids
	localparam logic [3:0] SND_BELL     = 4'd3;
	localparam logic [3:0] SND_BOUNDARY = 4'd4;
	localparam logic [3:0] SND_OFF      = 4'd5;
	localparam logic [3:0] SND_ON       = 4'd6;
	localparam logic [3:0] SND_BUZZ     = 4'd7;
	localparam logic [3:0] SND_START    = 4'd8;

	localparam int          RING_DEPTH = 32;
	localparam logic [31:0] WRAP_LIMIT = 32'd1000;

	// divisor and duration pairs, all sounds back to back
	localparam logic [15:0] SOUND_WORDS [36] = '{
		16'd662, 16'd5,
		16'd376, 16'd3, 16'd316, 16'd3,
		16'd4800, 16'd3,
		16'd2000, 16'd10,
		16'd8000, 16'd20,
		16'd2000, 16'd2, 16'd1800, 16'd2, 16'd1700, 16'd2, 16'd1500, 16'd2,
		16'd1400, 16'd2, 16'd1300, 16'd2, 16'd1200, 16'd2, 16'd1000, 16'd2,
		16'd900, 16'd2, 16'd800, 16'd2, 16'd700, 16'd2, 16'd500, 16'd2
	};

	// first word and word count per sound id, zero count for none
	localparam int SOUND_FIRST [16] = '{0, 0, 0, 0, 2, 6, 8, 10, 12, 0, 0, 0, 0, 0, 0, 0};
	localparam int SOUND_COUNT [16] = '{0, 0, 0, 2, 4, 2, 2, 2, 24, 0, 0, 0, 0, 0, 0, 0};

	typedef struct packed {
		logic        tone_on;
		logic [15:0] tone_divisor;
		logic        sound_dropped;
		logic        waiting;
	} tone_status_t;

	class tone_tracker;
		logic [15:0]  ring [RING_DEPTH];
		logic [4:0]   head;
		logic [4:0]   tail;
		logic [31:0]  ticks;
		logic [31:0]  deadline;
		logic         pending_tone;
		logic         gate;
		logic [15:0]  divisor;
		logic         enabled;
		tone_status_t expected_status [$];
		int           mismatches;

		function new();
			head = '0;
			tail = '0;
			ticks = '0;
			deadline = '0;
			pending_tone = 1'b0;
			gate = 1'b0;
			divisor = '0;
			enabled = 1'b1;
			mismatches = 0;
		endfunction

		function void set_enable(input logic value);
			enabled = value;
		endfunction

		function int outstanding();
			return expected_status.size();
		endfunction

		// apply one command to the mirrored player, return its status
		function tone_status_t advance_player(input logic cmd_mode, input logic [3:0] id);
			tone_status_t s;
			int           count;
			int           room;
			int           k;
			logic [4:0]   used;
			logic [31:0]  ahead;
			logic [15:0]  dur;
			s.sound_dropped = 1'b0;
			if (cmd_mode == MODE_QUEUE) begin
				count = SOUND_COUNT[id];
				if (enabled && count != 0) begin
					used = head - tail;
					room = RING_DEPTH - 1 - int'(used);
					if (count > room) begin
						s.sound_dropped = 1'b1;
					end else begin
						for (k = 0; k < count; k++) begin
							ring[head] = SOUND_WORDS[SOUND_FIRST[id] + k];
							head = head + 5'd1;
						end
					end
				end
			end else begin
				ticks = ticks + 32'd1;
				// end the tone unless its deadline is just ahead
				if (pending_tone) begin
					ahead = deadline - ticks;
					if (ahead == 32'd0 || ahead >= WRAP_LIMIT) begin
						gate = 1'b0;
						pending_tone = 1'b0;
					end
				end
				// start the next tone from the ring
				if (!pending_tone && tail != head) begin
					divisor = ring[tail];
					tail = tail + 5'd1;
					dur = ring[tail];
					tail = tail + 5'd1;
					gate = 1'b1;
					deadline = ticks + 32'(dur);
					pending_tone = 1'b1;
				end
			end
			s.tone_on = gate;
			s.tone_divisor = divisor;
			s.waiting = pending_tone;
			return s;
		endfunction

		function void note_item(input logic cmd_mode, input logic [3:0] id);
			expected_status.push_back(advance_player(cmd_mode, id));
		endfunction

		function void check_status(input tone_status_t got);
			tone_status_t want;
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status with no transaction pending, got on=%0b div=%0d drop=%0b wait=%0b",
						got.tone_on, got.tone_divisor, got.sound_dropped, got.waiting);
				return;
			end
			want = expected_status.pop_front();
			if (got.tone_on !== want.tone_on || got.tone_divisor !== want.tone_divisor ||
					got.sound_dropped !== want.sound_dropped || got.waiting !== want.waiting) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected on=%0b div=%0d drop=%0b wait=%0b, got on=%0b div=%0d drop=%0b wait=%0b",
						want.tone_on, want.tone_divisor, want.sound_dropped, want.waiting,
						got.tone_on, got.tone_divisor, got.sound_dropped, got.waiting);
			end
		endfunction
	endclass

endpackage

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the tone sequence player: directed sounds, drops and disabled
// queuing, then random tick and queue traffic with random sender gaps over
// several sound_enable settings; every status is checked against a tracker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tone_tb_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        mode = 1'b0;
	logic [3:0]  sound_id = 4'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = 1'b0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic        tone_on;
	logic [15:0] tone_divisor;
	logic        sound_dropped;
	logic        waiting;

	tone_tracker board = new();
	int          gap_limit = 0;
	int          idle_cycles = 0;

	tone_sequence_player_top #(
		.FIFO_DEPTH(RING_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.sound_id     (sound_id),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.tone_on      (tone_on),
		.tone_divisor (tone_divisor),
		.sound_dropped(sound_dropped),
		.waiting      (waiting)
	);

	// clock
	always #5 clk = ~clk;

	// status monitor
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_status('{tone_on, tone_divisor, sound_dropped, waiting});
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// send one command after a random gap
	task automatic play_item(input logic cmd_mode, input logic [3:0] id);
		int gap;
		gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= cmd_mode;
		sound_id <= id;
		do @(posedge clk); while (busy);
		board.note_item(cmd_mode, id);
	endtask

	// hold off until the block is idle and all status has come back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (busy || board.outstanding() != 0);
	endtask

	task automatic write_enable(input logic value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_enable(value);
	endtask

	// random command: mostly ticks, some queues, occasional bursts to force drops
	task automatic play_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			repeat (3) play_item(MODE_QUEUE, 4'($urandom_range(SND_BELL, SND_START)));
		end else if (r < 20) begin
			play_item(MODE_QUEUE, 4'($urandom_range(SND_BELL, SND_START)));
		end else if (r < 28) begin
			play_item(MODE_QUEUE, 4'($urandom_range(0, 15)));
		end else begin
			play_item(MODE_TICK, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		logic enable_plan [5];
		int   phase;
		int   n;
		enable_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, fill the ring, drop, unknown ids
		play_item(MODE_TICK, 4'd0);
		play_item(MODE_QUEUE, SND_START);
		play_item(MODE_QUEUE, SND_BELL);
		play_item(MODE_QUEUE, SND_BOUNDARY);
		play_item(MODE_QUEUE, SND_OFF);
		play_item(MODE_QUEUE, 4'd0);
		play_item(MODE_QUEUE, 4'd1);
		play_item(MODE_QUEUE, 4'd2);
		play_item(MODE_QUEUE, 4'd9);
		play_item(MODE_QUEUE, 4'hF);
		play_item(MODE_TICK, 4'hF);
		repeat (5) play_item(MODE_TICK, 4'd0);
		play_item(MODE_QUEUE, SND_ON);
		play_item(MODE_QUEUE, SND_BUZZ);

		// directed: queuing disabled
		write_enable(1'b0);
		play_item(MODE_QUEUE, SND_START);
		play_item(MODE_QUEUE, SND_BELL);
		play_item(MODE_TICK, 4'd0);
		write_enable(1'b1);

		// random phases over enable settings
		for (phase = 0; phase < 5; phase++) begin
			write_enable(enable_plan[phase]);
			for (n = 0; n < 76; n++) begin
				if (n % 30 == 0) begin
					case ($urandom_range(0, 2))
						0:       gap_limit = 0;
						1:       gap_limit = 3;
						default: gap_limit = 12;
					endcase
				end
				play_random();
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
